FILE: hw/rtl/confidence_gated_motion_supervisor_core_assert.svh
// Assertion macros shared by the supervisor RTL.
`ifndef CONFIDENCE_GATED_MOTION_SUPERVISOR_CORE_ASSERT_SVH
`define CONFIDENCE_GATED_MOTION_SUPERVISOR_CORE_ASSERT_SVH

// Clocked property, masked while reset is asserted.
`define CGMS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cgms assertion failed");

// Condition that must never hold.
`define CGMS_ASSERT_NEVER(label, cond) \
  `CGMS_ASSERT(label, !(cond))

`endif

FILE: hw/rtl/cgms_pkg.sv
// Types and constants of the confidence gated motion supervisor.
package cgms_pkg;

  localparam int unsigned PERMILLE   = 1000;
  localparam int unsigned PCT_W      = 10;
  localparam int unsigned STREAK_W   = 8;
  localparam int unsigned CMD_W      = 32;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned PRODUCT_W  = CMD_W + PCT_W;
  localparam int unsigned DIV_STEPS  = PRODUCT_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef enum logic [1:0] {
    MODE_HALT     = 2'd0,
    MODE_DEGRADED = 2'd1,
    MODE_NOMINAL  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THR   = 3'd0,
    CFG_LOW_THR    = 3'd1,
    CFG_PERSIST    = 3'd2,
    CFG_TQ_SCALE   = 3'd3,
    CFG_VL_SCALE   = 3'd4,
    CFG_TQ_LIMIT   = 3'd5,
    CFG_VL_LIMIT   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             veto;
  } cmd_t;

  // Clamp a magnitude to the limit, then restore the sign.
  function automatic cmd_t shape_cmd(input logic neg, input logic [CMD_W-1:0] mag,
                                     input logic [LIMIT_W-1:0] limit);
    cmd_t             res;
    logic [CMD_W-1:0] lim_ext;
    logic [CMD_W-1:0] clamped;
    lim_ext  = CMD_W'(limit);
    res.veto = mag > lim_ext;
    clamped  = res.veto ? lim_ext : mag;
    res.cmd  = neg ? (~clamped + CMD_W'(1)) : clamped;
    return res;
  endfunction

endpackage

FILE: hw/rtl/cgms_mul_div.sv
// Product of two operands divided by 1000, bit-serial restoring divider.
`include "confidence_gated_motion_supervisor_core_assert.svh"

module cgms_mul_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cgms_pkg::CMD_W-1:0]   multiplicand_i,
  input  logic [cgms_pkg::PCT_W-1:0]   factor_i,
  output logic                         done_o,
  output logic [cgms_pkg::CMD_W-1:0]   quotient_o
);
  import cgms_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [PCT_W-1:0]     rem_q, rem_d;
  logic [PRODUCT_W-1:0] pq_q, pq_d;
  logic [PCT_W:0]       trial;
  logic                 ge;

  assign trial = {rem_q, pq_q[PRODUCT_W-1]};
  assign ge    = trial >= (PCT_W+1)'(PERMILLE);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    pq_d   = pq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      pq_d   = PRODUCT_W'(multiplicand_i) * PRODUCT_W'(factor_i);
    end else if (busy_q) begin
      rem_d = ge ? PCT_W'(trial - (PCT_W+1)'(PERMILLE)) : trial[PCT_W-1:0];
      pq_d  = {pq_q[PRODUCT_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    pq_q  <= pq_d;
  end

  assign done_o     = done_q;
  assign quotient_o = pq_q[CMD_W-1:0];

  `CGMS_ASSERT(a_quot_fits, done_q |-> (pq_q[PRODUCT_W-1:CMD_W] == '0))
  `CGMS_ASSERT(a_rem_range, busy_q |-> (rem_q < PCT_W'(PERMILLE)))
  `CGMS_ASSERT_NEVER(a_start_busy, start_i && busy_q)

endmodule

FILE: hw/rtl/confidence_gated_motion_supervisor_core.sv
// Top level of the confidence gated motion supervisor.
// One transaction in, one result out. A window goes through ST_LOAD, ST_RUN and ST_FIN;
// its result is registered as it leaves ST_FIN, once the result register is free or
// taken, and the input side becomes ready at that same edge, so a new window is accepted
// only after the last is through. The time is set by the 42-step bit-serial divide by
// 1000 run for effective confidence, scaled torque and scaled velocity side by side.
// The result register lets the next window be accepted while the previous result waits.
// Configuration writes are taken every cycle and must only occur while idle.
`include "confidence_gated_motion_supervisor_core_assert.svh"

module confidence_gated_motion_supervisor_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cgms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cgms_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                sample_valid_i,
  input  logic                                intent_valid_i,
  input  logic [cgms_pkg::PCT_W-1:0]          confidence_i,
  input  logic [cgms_pkg::PCT_W-1:0]          reliability_i,
  input  logic signed [cgms_pkg::CMD_W-1:0]   torque_request_i,
  input  logic signed [cgms_pkg::CMD_W-1:0]   velocity_request_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          mode_o,
  output logic signed [cgms_pkg::CMD_W-1:0]   torque_command_o,
  output logic signed [cgms_pkg::CMD_W-1:0]   velocity_command_o,
  output logic [cgms_pkg::PCT_W-1:0]          effective_confidence_o,
  output logic                                veto_o
);
  import cgms_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [PCT_W-1:0]    high_thr_q, low_thr_q, tq_scale_q, vl_scale_q;
  logic [STREAK_W-1:0] persist_q;
  logic [LIMIT_W-1:0]  tq_limit_q, vl_limit_q;
  logic [STREAK_W-1:0] streak_q, streak_d;

  logic                ok_q;
  logic [PCT_W-1:0]    conf_q, rel_q;
  logic                tq_neg_q, vl_neg_q;
  logic [CMD_W-1:0]    tq_mag_q, vl_mag_q;
  logic [CMD_W-1:0]    tq_raw, vl_raw;

  logic                out_valid_q;
  mode_e               mode_q, mode_d;
  logic [CMD_W-1:0]    tq_cmd_q, tq_cmd_d, vl_cmd_q, vl_cmd_d;
  logic [PCT_W-1:0]    eff_q, eff_d;
  logic                veto_q, veto_d;

  logic                in_fire, fin_fire, start;
  logic                eff_done, tq_done, vl_done;
  logic [CMD_W-1:0]    eff_quot, tq_quot, vl_quot;
  logic [PCT_W-1:0]    eff;
  logic [STREAK_W-1:0] streak_inc;
  logic                degraded;
  cmd_t                tq_shape, vl_shape;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign fin_fire    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign start       = (state_q == ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= PCT_W'(750);
      low_thr_q  <= PCT_W'(450);
      persist_q  <= STREAK_W'(3);
      tq_scale_q <= PCT_W'(400);
      vl_scale_q <= PCT_W'(500);
      tq_limit_q <= LIMIT_W'(40000);
      vl_limit_q <= LIMIT_W'(6000000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HIGH_THR: high_thr_q <= cfg_data_i[PCT_W-1:0];
        CFG_LOW_THR:  low_thr_q  <= cfg_data_i[PCT_W-1:0];
        CFG_PERSIST:  persist_q  <= cfg_data_i[STREAK_W-1:0];
        CFG_TQ_SCALE: tq_scale_q <= cfg_data_i[PCT_W-1:0];
        CFG_VL_SCALE: vl_scale_q <= cfg_data_i[PCT_W-1:0];
        CFG_TQ_LIMIT: tq_limit_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_VL_LIMIT: vl_limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign tq_raw = torque_request_i;
  assign vl_raw = velocity_request_i;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ok_q     <= sample_valid_i && intent_valid_i &&
                  (confidence_i <= PCT_W'(PERMILLE)) && (reliability_i <= PCT_W'(PERMILLE));
      conf_q   <= confidence_i;
      rel_q    <= reliability_i;
      tq_neg_q <= tq_raw[CMD_W-1];
      vl_neg_q <= vl_raw[CMD_W-1];
      tq_mag_q <= tq_raw[CMD_W-1] ? (~tq_raw + CMD_W'(1)) : tq_raw;
      vl_mag_q <= vl_raw[CMD_W-1] ? (~vl_raw + CMD_W'(1)) : vl_raw;
    end
  end

  cgms_mul_div u_eff_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .multiplicand_i (CMD_W'(conf_q)),
    .factor_i       (rel_q),
    .done_o         (eff_done),
    .quotient_o     (eff_quot)
  );

  cgms_mul_div u_tq_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .multiplicand_i (tq_mag_q),
    .factor_i       (tq_scale_q),
    .done_o         (tq_done),
    .quotient_o     (tq_quot)
  );

  cgms_mul_div u_vl_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .multiplicand_i (vl_mag_q),
    .factor_i       (vl_scale_q),
    .done_o         (vl_done),
    .quotient_o     (vl_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_RUN;
      ST_RUN:  if (eff_done) state_d = ST_FIN;
      ST_FIN:  if (fin_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign eff        = eff_quot[PCT_W-1:0];
  assign streak_inc = (streak_q == '1) ? streak_q : streak_q + STREAK_W'(1);

  always_comb begin
    streak_d = '0;
    eff_d    = eff;
    if (!ok_q) begin
      mode_d = MODE_HALT;
      eff_d  = '0;
    end else if (eff < low_thr_q) begin
      streak_d = streak_inc;
      mode_d   = (streak_inc >= persist_q) ? MODE_HALT : MODE_DEGRADED;
    end else begin
      mode_d = (eff >= high_thr_q) ? MODE_NOMINAL : MODE_DEGRADED;
    end
  end

  assign degraded = (mode_d == MODE_DEGRADED);
  assign tq_shape = shape_cmd(tq_neg_q, degraded ? tq_quot : tq_mag_q, tq_limit_q);
  assign vl_shape = shape_cmd(vl_neg_q, degraded ? vl_quot : vl_mag_q, vl_limit_q);

  always_comb begin
    if (mode_d == MODE_HALT) begin
      tq_cmd_d = '0;
      vl_cmd_d = '0;
      veto_d   = 1'b0;
    end else begin
      tq_cmd_d = tq_shape.cmd;
      vl_cmd_d = vl_shape.cmd;
      veto_d   = tq_shape.veto || vl_shape.veto;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      streak_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        streak_q    <= streak_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      mode_q   <= mode_d;
      tq_cmd_q <= tq_cmd_d;
      vl_cmd_q <= vl_cmd_d;
      eff_q    <= eff_d;
      veto_q   <= veto_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign mode_o                 = mode_q;
  assign torque_command_o       = tq_cmd_q;
  assign velocity_command_o     = vl_cmd_q;
  assign effective_confidence_o = eff_q;
  assign veto_o                 = veto_q;

  `CGMS_ASSERT(a_div_lockstep, eff_done |-> (tq_done && vl_done && state_q == ST_RUN))
  `CGMS_ASSERT(a_halt_zero, (out_valid_q && mode_q == MODE_HALT) |->
                            (tq_cmd_q == '0 && vl_cmd_q == '0 && !veto_q))
  `CGMS_ASSERT(a_fin_after_done, (state_q == ST_FIN) |-> $past(eff_done) || $past(state_q == ST_FIN))
  `CGMS_ASSERT(a_eff_range, out_valid_q |-> (eff_q <= PCT_W'(PERMILLE)))

endmodule
